// ===== rtl/core/sssd_pkg.sv =====
// ----------------------------------------------------------------------------
// sssd_pkg
// Shared types, codes and helpers for the 7-segment scan display driver.
// ----------------------------------------------------------------------------
package sssd_pkg;

    // item opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // format codes
    localparam logic [2:0] FMT_HEX = 3'd0;
    localparam logic [2:0] FMT_DEC = 3'd1;
    localparam logic [2:0] FMT_DP0 = 3'd2;
    localparam logic [2:0] FMT_DP3 = 3'd5;

    localparam logic [7:0]  SEG_ZERO      = 8'h3f;
    localparam logic [7:0]  SEG_DP        = 8'h80;
    localparam logic [7:0]  CATHODE_RESET = 8'hff;
    localparam logic [31:0] PATTERN_RESET = 32'h7f7f7f7f;

    // decimal weights
    localparam logic [15:0] TEN_THOUSAND = 16'd10000;
    localparam logic [15:0] THOUSAND     = 16'd1000;
    localparam logic [15:0] HUNDRED      = 16'd100;
    localparam logic [15:0] TEN          = 16'd10;

    // register stages in the decimal split pipeline
    localparam int NUM_STAGES = 5;

    typedef struct packed {
        logic            opcode;
        logic [2:0]      fmt;
        logic [15:0]     value;
        logic [13:0]     rem;
        logic [3:0][3:0] dec;
    } pipe_t;

    typedef struct packed {
        logic [3:0]  digit;
        logic [15:0] rem;
    } split_t;

    // segment code, bit0 A .. bit6 G
    function automatic logic [7:0] seg7(input logic [3:0] nib);
        logic [7:0] s;
        case (nib)
            4'h0: s = 8'h3f;
            4'h1: s = 8'h06;
            4'h2: s = 8'h5b;
            4'h3: s = 8'h4f;
            4'h4: s = 8'h66;
            4'h5: s = 8'h6d;
            4'h6: s = 8'h7d;
            4'h7: s = 8'h07;
            4'h8: s = 8'h7f;
            4'h9: s = 8'h6f;
            4'ha: s = 8'h77;
            4'hb: s = 8'h7c;
            4'hc: s = 8'h58;
            4'hd: s = 8'h5e;
            4'he: s = 8'h79;
            default: s = 8'h71;
        endcase
        return s;
    endfunction

    // one decimal digit by parallel compare against k*unit, k = 1..9
    function automatic split_t dec_split(input logic [15:0] x, input logic [15:0] unit);
        split_t      s;
        logic [16:0] thr;
        logic [16:0] sel;
        s.digit = '0;
        thr     = '0;
        sel     = '0;
        for (int k = 1; k <= 9; k++)
        begin
            thr = thr + {1'b0, unit};
            if ({1'b0, x} >= thr)
            begin
                s.digit = 4'(k);
                sel     = thr;
            end
        end
        s.rem = x - sel[15:0];
        return s;
    endfunction

    // digits to 32-bit pattern with blanking and decimal point
    function automatic logic [31:0] format_word(input logic [2:0] fmt,
                                                input logic [15:0] value,
                                                input logic [3:0][3:0] dec);
        logic [3:0][7:0] seg;
        logic            has_pt;
        logic [1:0]      pt;
        logic            going;
        has_pt = (fmt inside {[FMT_DP0:FMT_DP3]});
        pt     = 2'(fmt - FMT_DP0);
        for (int i = 0; i < 4; i++)
        begin
            seg[i] = seg7((fmt == FMT_HEX) ? value[4*i +: 4] : dec[i]);
        end
        going = 1'b1;
        for (int i = 3; i > 0; i--)
        begin
            if (going && !(has_pt && (2'(i) <= pt)) && (seg[i] == SEG_ZERO))
            begin
                seg[i] = '0;
            end
            else
            begin
                going = 1'b0;
            end
        end
        if (has_pt)
        begin
            seg[pt] = seg[pt] | SEG_DP;
        end
        return seg;
    endfunction

endpackage

// ===== rtl/core/sssd_in_if.sv =====
// ----------------------------------------------------------------------------
// sssd_in_if
// Item channel: scan tick or pattern load.
// ----------------------------------------------------------------------------
interface sssd_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] value;
    logic [2:0]  format;

    modport source (output valid, opcode, value, format, input ready);
    modport sink   (input valid, opcode, value, format, output ready);
endinterface

// ===== rtl/core/sssd_out_if.sv =====
// ----------------------------------------------------------------------------
// sssd_out_if
// Result channel: line levels and current pattern.
// ----------------------------------------------------------------------------
interface sssd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  segment_lines;
    logic [3:0]  digit_lines;
    logic [31:0] shown_pattern;

    modport source (output valid, segment_lines, digit_lines, shown_pattern, input ready);
    modport sink   (input valid, segment_lines, digit_lines, shown_pattern, output ready);
endinterface

// ===== rtl/core/sssd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sssd_cfg_if
// Configuration write channel for the display enable bit.
// ----------------------------------------------------------------------------
interface sssd_cfg_if;
    logic valid;
    logic ready;
    logic display_enable;

    modport source (output valid, display_enable, input ready);
    modport sink   (input valid, display_enable, output ready);
endinterface

// ===== rtl/core/sssd_dec.sv =====
// ----------------------------------------------------------------------------
// sssd_dec
// Decimal split pipeline: mod 10000, then thousands, hundreds, then tens and units.
// ----------------------------------------------------------------------------
module sssd_dec (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sssd_pkg::pipe_t     in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sssd_pkg::pipe_t     out_data
);

    logic [sssd_pkg::NUM_STAGES-1:0] valid_reg;
    logic [sssd_pkg::NUM_STAGES-1:0] valid_next;
    logic [sssd_pkg::NUM_STAGES:0]   stage_ready;
    sssd_pkg::pipe_t                 data_reg  [sssd_pkg::NUM_STAGES];
    sssd_pkg::pipe_t                 data_next [sssd_pkg::NUM_STAGES];
    sssd_pkg::split_t                s_10k;
    sssd_pkg::split_t                s_1k;
    sssd_pkg::split_t                s_100;
    sssd_pkg::split_t                s_10;

    // a stage loads when it is empty or its beat moves on
    always_comb
    begin
        stage_ready[sssd_pkg::NUM_STAGES] = out_ready;
        for (int i = sssd_pkg::NUM_STAGES - 1; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = in_valid;
        for (int i = 1; i < sssd_pkg::NUM_STAGES; i++)
        begin
            valid_next[i] = valid_reg[i-1];
        end
    end

    always_comb
    begin
        s_10k = sssd_pkg::dec_split(data_reg[0].value, sssd_pkg::TEN_THOUSAND);
        s_1k  = sssd_pkg::dec_split({2'b00, data_reg[1].rem}, sssd_pkg::THOUSAND);
        s_100 = sssd_pkg::dec_split({2'b00, data_reg[2].rem}, sssd_pkg::HUNDRED);
        s_10  = sssd_pkg::dec_split({2'b00, data_reg[3].rem}, sssd_pkg::TEN);

        data_next[0] = in_data;

        data_next[1]     = data_reg[0];
        data_next[1].rem = s_10k.rem[13:0];

        data_next[2]        = data_reg[1];
        data_next[2].dec[3] = s_1k.digit;
        data_next[2].rem    = s_1k.rem[13:0];

        data_next[3]        = data_reg[2];
        data_next[3].dec[2] = s_100.digit;
        data_next[3].rem    = s_100.rem[13:0];

        data_next[4]        = data_reg[3];
        data_next[4].dec[1] = s_10.digit;
        data_next[4].dec[0] = s_10.rem[3:0];
        data_next[4].rem    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < sssd_pkg::NUM_STAGES; i++)
            begin
                if (stage_ready[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < sssd_pkg::NUM_STAGES; i++)
        begin
            if (stage_ready[i])
            begin
                data_reg[i] <= data_next[i];
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[sssd_pkg::NUM_STAGES-1];
    assign out_data  = data_reg[sssd_pkg::NUM_STAGES-1];

endmodule

// ===== rtl/core/seven_segment_scan_display.sv =====
// ----------------------------------------------------------------------------
// seven_segment_scan_display
// Scan driver for a 4-digit common-anode 7-segment display.
// ----------------------------------------------------------------------------
// Each beat on the item channel is either a scan tick, which lights at most
// one of the 32 LEDs and advances the 5-bit scan position, or a load, which
// formats a 16-bit value (hex, or low four decimal digits with optional
// point) into the 32-bit segment pattern. Every item gives one result beat
// with the cathode levels, anode levels and current pattern. One item is
// taken per clock when the result side keeps up. Five stages split the
// value into decimal digits (input register, mod 10000, thousands,
// hundreds, then tens and units) and one stage applies the item to the
// scan state, which doubles as the result register. All scan state changes
// happen in that last stage, so items take effect in order. The display
// enable register resets to 1 and is written through the cfg channel, which
// is always ready; it should only be changed while no items are in flight.
// ----------------------------------------------------------------------------
module seven_segment_scan_display (
    input  logic       clk,
    input  logic       rst_n,
    sssd_in_if.sink    item,
    sssd_out_if.source result,
    sssd_cfg_if.sink   cfg
);

    sssd_pkg::pipe_t in_data;
    sssd_pkg::pipe_t dec_data;
    logic            dec_valid;
    logic            dec_ready;
    logic            take;

    // scan state; these registers also drive the result payload
    logic [4:0]  scan_reg;
    logic [4:0]  scan_next;
    logic [7:0]  cathode_reg;
    logic [7:0]  cathode_next;
    logic [3:0]  anode_reg;
    logic [3:0]  anode_next;
    logic [31:0] pattern_reg;
    logic [31:0] pattern_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic        enable_reg;

    // tick decode
    logic [2:0]  seg_sel;
    logic [2:0]  seg_prev;
    logic        lit;

    always_comb
    begin
        in_data        = '0;
        in_data.opcode = item.opcode;
        in_data.fmt    = item.format;
        in_data.value  = item.value;
    end

    sssd_dec u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .in_data   (in_data),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    // last stage loads when the previous result has gone
    assign dec_ready = !res_valid_reg || result.ready;
    assign take      = dec_valid && dec_ready;

    assign seg_sel  = scan_reg[2:0];
    assign seg_prev = seg_sel - 3'd1;
    assign lit      = pattern_reg[scan_reg];

    always_comb
    begin
        scan_next    = scan_reg;
        cathode_next = cathode_reg;
        anode_next   = anode_reg;
        pattern_next = pattern_reg;
        case (dec_data.opcode)
            sssd_pkg::OP_TICK:
            begin
                // release previous line, pull current one if its LED is on
                cathode_next           = cathode_reg;
                cathode_next[seg_prev] = 1'b1;
                if (lit)
                begin
                    cathode_next[seg_sel] = 1'b0;
                end
                // position bits 4:3 pick the digit, 0 is the rightmost (DIG4)
                anode_next = '0;
                if (enable_reg && lit)
                begin
                    anode_next[~scan_reg[4:3]] = 1'b1;
                end
                scan_next = scan_reg + 5'd1;
            end
            sssd_pkg::OP_LOAD:
            begin
                pattern_next = sssd_pkg::format_word(dec_data.fmt, dec_data.value,
                                                     dec_data.dec);
            end
            default:
            begin
                pattern_next = pattern_reg;
            end
        endcase
    end

    always_comb
    begin
        if (take)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= '0;
            cathode_reg   <= sssd_pkg::CATHODE_RESET;
            anode_reg     <= '0;
            pattern_reg   <= sssd_pkg::PATTERN_RESET;
            res_valid_reg <= 1'b0;
            enable_reg    <= 1'b1;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                scan_reg    <= scan_next;
                cathode_reg <= cathode_next;
                anode_reg   <= anode_next;
                pattern_reg <= pattern_next;
            end
            if (cfg.valid)
            begin
                enable_reg <= cfg.display_enable;
            end
        end
    end

    assign cfg.ready            = 1'b1;
    assign result.valid         = res_valid_reg;
    assign result.segment_lines = cathode_reg;
    assign result.digit_lines   = anode_reg;
    assign result.shown_pattern = pattern_reg;

endmodule

// ===== rtl/core/sssd_checker.sv =====
// ----------------------------------------------------------------------------
// sssd_checker
// Port-level checks on the scan display result channel.
// ----------------------------------------------------------------------------
module sssd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [7:0]  segment_lines,
    input logic [3:0]  digit_lines,
    input logic [31:0] shown_pattern
);

    // at most one digit driven at a time
    a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $onehot0(digit_lines))
        else $error("more than one digit anode driven");

    // a driven digit always has a segment pulled low
    a_digit_has_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (digit_lines != 4'h0)) |-> (segment_lines != 8'hff))
        else $error("digit driven with all segments released");

    // a driven digit means the pattern has a lit LED
    a_digit_has_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (digit_lines != 4'h0)) |-> (shown_pattern != 32'h0))
        else $error("digit driven with empty pattern");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(segment_lines)
            && $stable(digit_lines) && $stable(shown_pattern)))
        else $error("stalled result changed");

endmodule

bind seven_segment_scan_display sssd_checker u_sssd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .segment_lines (result.segment_lines),
    .digit_lines   (result.digit_lines),
    .shown_pattern (result.shown_pattern)
);

// ===== tb/seven_segment_scan_display_tb.sv =====
// ----------------------------------------------------------------------------
// seven_segment_scan_display_tb
// Self-checking bench for the 4-digit 7-segment scan driver.
// ----------------------------------------------------------------------------
// Starts with a short table of directed items: values fixed by reset,
// extreme values, every format code and the blanking and point corner
// cases. Random scan ticks and pattern loads follow, run under three
// handshake profiles and with both settings of display_enable. A built-in
// model of the scan state predicts each result beat not fixed by the table,
// and the DUT output is compared against it in order.
// ----------------------------------------------------------------------------
module seven_segment_scan_display_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Format codes that the package does not name.
    localparam logic [2:0] FMT_DP1    = sssd_pkg::FMT_DP0 + 3'd1;
    localparam logic [2:0] FMT_DP2    = sssd_pkg::FMT_DP0 + 3'd2;
    localparam logic [2:0] FMT_SPARE6 = 3'd6;
    localparam logic [2:0] FMT_SPARE7 = 3'd7;

    localparam int DRAIN_CYCLES   = 12;   // extra margin after draining
    localparam int STALL_LIMIT    = 1000; // cycles with no beat on any channel
    localparam int LONG_HOLD      = 300;  // long result-side hold-off
    localparam int REPORT_LIMIT   = 10;

    // Segment glyphs, bit0 A .. bit6 G.
    localparam logic [7:0] GLYPH [16] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
        8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h58, 8'h5e, 8'h79, 8'h71
    };

    // One result beat.
    typedef struct packed {
        logic [7:0]  seg_lines;
        logic [3:0]  dig_lines;
        logic [31:0] pattern;
    } lines_t;

    // One row of the directed table. When fixed is set, the expected lines
    // are taken from the row rather than from the model.
    typedef struct packed {
        logic        op;
        logic [15:0] value;
        logic [2:0]  fmt;
        logic        fixed;
        lines_t      want;
    } drow_t;

    localparam int NUM_DIRECTED = 25;

    localparam drow_t DIRECTED [NUM_DIRECTED] = '{
        // first tick after reset: 8888 pattern, position 0 lights DIG4 seg A
        '{sssd_pkg::OP_TICK, 16'h0000, sssd_pkg::FMT_HEX, 1'b1, '{8'hfe, 4'h8, 32'h7f7f7f7f}},
        // second tick releases A, pulls B
        '{sssd_pkg::OP_TICK, 16'hffff, FMT_SPARE7, 1'b1, '{8'hfd, 4'h8, 32'h7f7f7f7f}},
        // loads leave the line levels alone
        '{sssd_pkg::OP_LOAD, 16'hffff, sssd_pkg::FMT_HEX, 1'b1, '{8'hfd, 4'h8, 32'h71717171}},
        '{sssd_pkg::OP_LOAD, 16'h0000, sssd_pkg::FMT_HEX, 1'b1, '{8'hfd, 4'h8, 32'h0000003f}},
        '{sssd_pkg::OP_LOAD, 16'hffff, sssd_pkg::FMT_DEC, 1'b1, '{8'hfd, 4'h8, 32'h6d6d4f6d}},
        // all zero with point on the leftmost digit: nothing blanked
        '{sssd_pkg::OP_LOAD, 16'h0000, sssd_pkg::FMT_DP3, 1'b1, '{8'hfd, 4'h8, 32'hbf3f3f3f}},
        // all zero with point on the rightmost digit
        '{sssd_pkg::OP_LOAD, 16'h0000, sssd_pkg::FMT_DP0, 1'b1, '{8'hfd, 4'h8, 32'h000000bf}},
        // spare format codes act as plain decimal
        '{sssd_pkg::OP_LOAD, 16'd7,    FMT_SPARE6, 1'b1, '{8'hfd, 4'h8, 32'h00000007}},
        '{sssd_pkg::OP_LOAD, 16'd10000, FMT_SPARE7, 1'b1, '{8'hfd, 4'h8, 32'h0000003f}},
        // point keeps the zero digit it sits on
        '{sssd_pkg::OP_LOAD, 16'd5,    FMT_DP1,    1'b1, '{8'hfd, 4'h8, 32'h0000bf6d}},
        '{sssd_pkg::OP_LOAD, 16'd42,   FMT_DP2,    1'b1, '{8'hfd, 4'h8, 32'h00bf665b}},
        '{sssd_pkg::OP_LOAD, 16'h1234, sssd_pkg::FMT_HEX, 1'b1, '{8'hfd, 4'h8, 32'h065b4f66}},
        // hex blanks leading zeros but not inner ones
        '{sssd_pkg::OP_LOAD, 16'h00a0, sssd_pkg::FMT_HEX, 1'b1, '{8'hfd, 4'h8, 32'h0000773f}},
        '{sssd_pkg::OP_LOAD, 16'd9999, sssd_pkg::FMT_DEC, 1'b1, '{8'hfd, 4'h8, 32'h6f6f6f6f}},
        '{sssd_pkg::OP_LOAD, 16'h8000, sssd_pkg::FMT_HEX, 1'b1, '{8'hfd, 4'h8, 32'h7f3f3f3f}},
        // ticks through positions 2..11, checked by the model
        '{sssd_pkg::OP_TICK, 16'h5555, sssd_pkg::FMT_HEX, 1'b0, '0},
        '{sssd_pkg::OP_TICK, 16'haaaa, sssd_pkg::FMT_DEC, 1'b0, '0},
        '{sssd_pkg::OP_TICK, 16'h0000, sssd_pkg::FMT_HEX, 1'b0, '0},
        '{sssd_pkg::OP_TICK, 16'h0000, sssd_pkg::FMT_HEX, 1'b0, '0},
        '{sssd_pkg::OP_TICK, 16'h0000, sssd_pkg::FMT_HEX, 1'b0, '0},
        '{sssd_pkg::OP_TICK, 16'h0000, sssd_pkg::FMT_HEX, 1'b0, '0},
        '{sssd_pkg::OP_TICK, 16'h0000, sssd_pkg::FMT_HEX, 1'b0, '0},
        '{sssd_pkg::OP_TICK, 16'h0000, sssd_pkg::FMT_HEX, 1'b0, '0},
        '{sssd_pkg::OP_TICK, 16'h0000, sssd_pkg::FMT_HEX, 1'b0, '0},
        '{sssd_pkg::OP_TICK, 16'h0000, sssd_pkg::FMT_HEX, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    sssd_in_if  item_ch ();
    sssd_out_if result_ch ();
    sssd_cfg_if cfg_ch ();

    seven_segment_scan_display dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    // Display model state.
    logic [4:0]  scan_pos_m;
    logic [7:0]  cathodes_m;
    logic [3:0]  anodes_m;
    logic [31:0] pattern_m;
    logic        enable_m;

    lines_t pending_lines [$];

    int mismatches;
    int result_beats;
    int idle_cycles;
    int tx_idle_pct;
    int rx_idle_pct;
    bit long_hold_req;

    // Side-band tags that travel with the beat on the item channel.
    logic   tag_fixed;
    lines_t tag_want;

    // Pattern for a load: digit glyphs, leading-zero blanking, point.
    function automatic logic [31:0] load_pattern(input logic [15:0] value,
                                                 input logic [2:0] fmt);
        logic [7:0] dg [4];
        int         pt;
        int         rest;
        pt = -1;
        if (fmt == sssd_pkg::FMT_HEX)
        begin
            for (int i = 0; i < 4; i++)
                dg[i] = GLYPH[value[4*i +: 4]];
        end
        else
        begin
            rest = int'(value) % 10000;
            for (int i = 0; i < 4; i++)
            begin
                dg[i] = GLYPH[rest % 10];
                rest  = rest / 10;
            end
            if (fmt >= sssd_pkg::FMT_DP0 && fmt <= sssd_pkg::FMT_DP3)
                pt = int'(fmt) - int'(sssd_pkg::FMT_DP0);
        end
        // blank zeros from the left, stopping at the point or a nonzero digit
        for (int i = 3; i > 0; i--)
        begin
            if (i <= pt || dg[i] != sssd_pkg::SEG_ZERO)
                break;
            dg[i] = 8'h00;
        end
        if (pt >= 0)
            dg[pt] = dg[pt] | sssd_pkg::SEG_DP;
        return {dg[3], dg[2], dg[1], dg[0]};
    endfunction

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Result side: random backpressure, plus one long hold-off on request.
    // The hold is counted here so the sender keeps offering items meanwhile.
    // ------------------------------------------------------------------------
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            result_ch.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: model update on accepted items and config writes, in-order
    // compare on accepted results. All channel values are sampled before the
    // edge's nonblocking updates land, so ordering within a step is moot.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        lines_t     got;
        lines_t     want;
        logic [2:0] seg_sel;
        logic [2:0] prev_sel;
        logic [1:0] dig_sel;
        logic       lit;
        if (rst_n)
        begin
            // results first: an item accepted this edge cannot have its
            // result out on the same edge
            if (result_ch.valid && result_ch.ready)
            begin
                got = '{result_ch.segment_lines, result_ch.digit_lines,
                        result_ch.shown_pattern};
                if (pending_lines.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"[%0t] result beat %0d with nothing expected:",
                                  " seg %h dig %h pat %h"},
                                 $realtime, result_beats, got.seg_lines, got.dig_lines,
                                 got.pattern);
                end
                else
                begin
                    want = pending_lines.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"[%0t] result beat %0d: seg exp %h got %h,",
                                      " dig exp %h got %h, pat exp %h got %h"},
                                     $realtime, result_beats,
                                     want.seg_lines, got.seg_lines,
                                     want.dig_lines, got.dig_lines,
                                     want.pattern, got.pattern);
                    end
                end
                result_beats++;
            end

            if (cfg_ch.valid && cfg_ch.ready)
                enable_m = cfg_ch.display_enable;

            if (item_ch.valid && item_ch.ready)
            begin
                if (item_ch.opcode == sssd_pkg::OP_TICK)
                begin
                    // release the previous cathode, pull this one if lit,
                    // and enable this digit's anode only when allowed
                    seg_sel  = scan_pos_m[2:0];
                    prev_sel = seg_sel - 3'd1;
                    dig_sel  = 2'd3 - scan_pos_m[4:3];
                    lit      = pattern_m[scan_pos_m];
                    anodes_m = 4'h0;
                    cathodes_m[prev_sel] = 1'b1;
                    if (lit)
                        cathodes_m[seg_sel] = 1'b0;
                    if (enable_m && lit)
                        anodes_m[dig_sel] = 1'b1;
                    scan_pos_m = scan_pos_m + 5'd1;
                end
                else
                begin
                    pattern_m = load_pattern(item_ch.value, item_ch.format);
                end
                if (tag_fixed)
                    pending_lines.push_back(tag_want);
                else
                    pending_lines.push_back('{cathodes_m, anodes_m, pattern_m});
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any accepted beat on any channel counts as progress.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers. Each is entered and left at a rising edge. valid is
    // left high after a beat so back-to-back items need no extra write.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [15:0] value,
                             input logic [2:0] fmt, input logic fixed,
                             input lines_t want);
        while ($urandom_range(99, 0) < tx_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.opcode <= op;
        item_ch.value  <= value;
        item_ch.format <= fmt;
        tag_fixed      <= fixed;
        tag_want       <= want;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // Stop offering and wait until every expected result beat has arrived.
    // At least one edge passes, so the last accepted item is already queued.
    task automatic drain_results;
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_lines.size() != 0);
    endtask

    // Reconfigure only with the pipe empty; every item gives a result, so
    // the extra cycles are only margin.
    task automatic write_enable(input logic en);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.display_enable <= en;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly scan ticks with a load now and then, so each pattern gets
    // scanned through a good share of its 32 positions.
    task automatic random_items(input int count, input int hold_at, input int pause_at);
        logic op;
        for (int k = 0; k < count; k++)
        begin
            if (k == hold_at)
                long_hold_req = 1'b1;
            if (k == pause_at)
                drain_results();
            op = ($urandom_range(7, 0) == 0) ? sssd_pkg::OP_LOAD : sssd_pkg::OP_TICK;
            send_item(op, 16'($urandom_range(65535, 0)), 3'($urandom_range(7, 0)),
                      1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        item_ch.valid         = 1'b0;
        item_ch.opcode        = sssd_pkg::OP_TICK;
        item_ch.value         = '0;
        item_ch.format        = sssd_pkg::FMT_HEX;
        cfg_ch.valid          = 1'b0;
        cfg_ch.display_enable = 1'b1;
        tag_fixed             = 1'b0;
        tag_want              = '0;
        long_hold_req         = 1'b0;
        mismatches            = 0;
        result_beats          = 0;
        idle_cycles           = 0;
        tx_idle_pct           = 0;
        rx_idle_pct           = 0;

        // model reset state
        scan_pos_m = '0;
        cathodes_m = sssd_pkg::CATHODE_RESET;
        anodes_m   = '0;
        pattern_m  = sssd_pkg::PATTERN_RESET;
        enable_m   = 1'b1;

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, display_enable still at its reset value
        tx_idle_pct = 21;
        rx_idle_pct = 77;
        for (int r = 0; r < NUM_DIRECTED; r++)
            send_item(DIRECTED[r].op, DIRECTED[r].value, DIRECTED[r].fmt,
                      DIRECTED[r].fixed, DIRECTED[r].want);

        // sender mostly busy, receiver mostly stalling; anodes held off
        write_enable(1'b0);
        random_items(400, -1, -1);

        // the other way round, anodes allowed
        tx_idle_pct = 77;
        rx_idle_pct = 21;
        write_enable(1'b1);
        random_items(400, -1, -1);

        // full rate, with one long result-side hold that backs the pipe up
        // and one pause of the sender until everything has come out
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_enable(1'b0);
        random_items(625, 100, 400);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_lines.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sssd_pkg.sv
rtl/core/sssd_in_if.sv
rtl/core/sssd_out_if.sv
rtl/core/sssd_cfg_if.sv
rtl/core/sssd_dec.sv
rtl/core/seven_segment_scan_display.sv
rtl/core/sssd_checker.sv
tb/seven_segment_scan_display_tb.sv
